// ----- rtl/core/isfp_pkg.sv -----
// ----------------------------------------------------------------------------
// isfp_pkg
// shared types and constants of the imu serial frame parser
// ----------------------------------------------------------------------------
package isfp_pkg;

  // frame layout
  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;
  localparam int         FRAME_LEN  = 11;
  localparam int         CNT_W      = 4;
  // bytes 0..7 are stored; only bytes 1..7 are ever read back
  localparam int         BUF_DEPTH  = 8;
  localparam int         BUF_IDX_W  = $clog2(BUF_DEPTH);

  // fixed-point scaling: rate z in 1/16 dps, yaw in 1/128 degree
  localparam int RZ_MUL   = 125;
  localparam int RZ_SHIFT = 7;
  localparam int RZ_PW    = 24;
  localparam int YAW_MUL   = 45;
  localparam int YAW_SHIFT = 6;
  localparam int YAW_PW    = 22;

  // frame status codes
  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_ACCEL   = 3'd1;
  localparam logic [2:0] ST_RATE    = 3'd2;
  localparam logic [2:0] ST_ANGLE   = 3'd3;
  localparam logic [2:0] ST_BADSUM  = 3'd4;
  localparam logic [2:0] ST_UNKNOWN = 3'd5;

  // command queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_ACCEL   = 3'd1,
    OP_RATE    = 3'd2,
    OP_ANGLE   = 3'd3,
    OP_BADSUM  = 3'd4,
    OP_UNKNOWN = 3'd5,
    OP_CLRYAW  = 3'd6
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e            op;
    logic signed [15:0] w0;
    logic signed [15:0] w1;
    logic signed [15:0] w2;
  } cmd_t;

endpackage

// ----- rtl/core/isfp_front.sv -----
// ----------------------------------------------------------------------------
// isfp_front
// byte assembly, running checksum and frame classification
// ----------------------------------------------------------------------------
module isfp_front import isfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       action_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       buf_q [BUF_DEPTH];
  logic             buf_we;

  always_comb begin
    count_d    = count_q;
    sum_d      = sum_q;
    buf_we     = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.w0   = $signed({buf_q[3], buf_q[2]});
    cmd_o.w1   = $signed({buf_q[5], buf_q[4]});
    cmd_o.w2   = $signed({buf_q[7], buf_q[6]});
    if (action_i) begin
      cmd_o.op = OP_CLRYAW;
    end else if (count_q == '0 && rx_byte_i != HDR_BYTE) begin
      cmd_o.op = OP_NONE;
    end else if (count_q < CNT_W'(FRAME_LEN - 1)) begin
      buf_we  = count_q < CNT_W'(BUF_DEPTH);
      sum_d   = sum_q + rx_byte_i;
      count_d = count_q + 1'b1;
    end else begin
      // checksum byte closes the frame
      if (sum_q != rx_byte_i) begin
        cmd_o.op = OP_BADSUM;
      end else if (buf_q[1] == TYPE_ACCEL) begin
        cmd_o.op = OP_ACCEL;
      end else if (buf_q[1] == TYPE_RATE) begin
        cmd_o.op = OP_RATE;
      end else if (buf_q[1] == TYPE_ANGLE) begin
        cmd_o.op = OP_ANGLE;
      end else begin
        cmd_o.op = OP_UNKNOWN;
      end
      count_d = '0;
      sum_d   = '0;
    end
  end

  assign push_o = accept_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && buf_we) begin
      buf_q[count_q[BUF_IDX_W-1:0]] <= rx_byte_i;
    end
  end

endmodule

// ----- rtl/core/isfp_queue.sv -----
// ----------------------------------------------------------------------------
// isfp_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module isfp_queue import isfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = count_q == QCNT_W'(QDEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/core/isfp_back.sv -----
// ----------------------------------------------------------------------------
// isfp_back
// measurement stores, fixed-point scaling and result register
// ----------------------------------------------------------------------------
module isfp_back import isfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] accel_x_o,
  output logic signed [15:0] accel_y_o,
  output logic signed [15:0] accel_z_o,
  output logic signed [15:0] rate_x_o,
  output logic signed [15:0] rate_y_o,
  output logic signed [15:0] rate_z_o,
  output logic signed [15:0] rate_z_scaled_o,
  output logic signed [15:0] yaw_angle_o,
  output logic [2:0]         frame_status_o
);

  logic                     out_valid_q;
  logic signed [15:0]       acc_q [3];
  logic signed [15:0]       rate_q [3];
  logic signed [15:0]       rz_q, yaw_q;
  logic [2:0]               status_q, status_d;
  logic signed [RZ_PW-1:0]  rz_prod;
  logic signed [YAW_PW-1:0] yaw_prod;

  assign pop_o = cmd_valid_i && (!out_valid_q || !out_stall_i);

  // arithmetic shift of the product gives the floor
  assign rz_prod  = RZ_PW'(cmd_i.w2) * RZ_PW'(RZ_MUL);
  assign yaw_prod = YAW_PW'(cmd_i.w2) * YAW_PW'(YAW_MUL);

  always_comb begin
    case (cmd_i.op)
      OP_ACCEL:   status_d = ST_ACCEL;
      OP_RATE:    status_d = ST_RATE;
      OP_ANGLE:   status_d = ST_ANGLE;
      OP_BADSUM:  status_d = ST_BADSUM;
      OP_UNKNOWN: status_d = ST_UNKNOWN;
      default:    status_d = ST_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= ST_NONE;
      for (int i = 0; i < 3; i++) begin
        acc_q[i]  <= '0;
        rate_q[i] <= '0;
      end
      rz_q  <= '0;
      yaw_q <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        status_q <= status_d;
        case (cmd_i.op)
          OP_ACCEL: begin
            acc_q[0] <= cmd_i.w0;
            acc_q[1] <= cmd_i.w1;
            acc_q[2] <= cmd_i.w2;
          end
          OP_RATE: begin
            rate_q[0] <= cmd_i.w0;
            rate_q[1] <= cmd_i.w1;
            rate_q[2] <= cmd_i.w2;
            rz_q      <= rz_prod[RZ_SHIFT +: 16];
          end
          OP_ANGLE: begin
            yaw_q <= yaw_prod[YAW_SHIFT +: 16];
          end
          OP_CLRYAW: begin
            yaw_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accel_x_o       = acc_q[0];
  assign accel_y_o       = acc_q[1];
  assign accel_z_o       = acc_q[2];
  assign rate_x_o        = rate_q[0];
  assign rate_y_o        = rate_q[1];
  assign rate_z_o        = rate_q[2];
  assign rate_z_scaled_o = rz_q;
  assign yaw_angle_o     = yaw_q;
  assign frame_status_o  = status_q;

endmodule

// ----- rtl/core/imu_serial_frame_parser_unit.sv -----
// ----------------------------------------------------------------------------
// imu_serial_frame_parser_unit
// assembles 11-byte imu frames and keeps the latest measurements
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o with action_i and rx_byte_i; a
//   transaction completes on a rising edge with valid high and stall low
// output channel: out_valid_o / out_stall_i; every input transaction gives
//   exactly one output transaction with all stored values and a frame status
// path: the front classifies in the accepting cycle and writes the command
//   queue, and the result register loads from the queue when the back
//   pops the entry
// throughput: one transaction per cycle unless the queue is full; a running
//   checksum lets the front check the closing byte in the accepting cycle;
//   the back's two constant multiplies (16 x 7, 16 x 6) give scaled values
// a stalled receiver holds the result register; the two-entry queue fills
//   and in_stall_o then rises until the receiver takes a result
// reset clears the frame counter, checksum, all measurement stores and the
//   queue; the result register comes up empty
// ----------------------------------------------------------------------------
module imu_serial_frame_parser_unit import isfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] accel_x_o,
  output logic signed [15:0] accel_y_o,
  output logic signed [15:0] accel_z_o,
  output logic signed [15:0] rate_x_o,
  output logic signed [15:0] rate_y_o,
  output logic signed [15:0] rate_z_o,
  output logic signed [15:0] rate_z_scaled_o,
  output logic signed [15:0] yaw_angle_o,
  output logic [2:0]         frame_status_o
);

  logic accept;
  logic push, q_full, q_valid, pop;
  cmd_t front_cmd, back_cmd;

  // the queue being full is the only reason to hold off the sender
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  isfp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .action_i  (action_i),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .cmd_o     (front_cmd)
  );

  isfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (back_cmd)
  );

  // stores double as the result register
  isfp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (back_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .accel_x_o       (accel_x_o),
    .accel_y_o       (accel_y_o),
    .accel_z_o       (accel_z_o),
    .rate_x_o        (rate_x_o),
    .rate_y_o        (rate_y_o),
    .rate_z_o        (rate_z_o),
    .rate_z_scaled_o (rate_z_scaled_o),
    .yaw_angle_o     (yaw_angle_o),
    .frame_status_o  (frame_status_o)
  );

endmodule
